// File: rtl/magc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magc_pkg
// Shared constants for the accelerometer magnitude block: configuration
// register map, field widths and register reset values.
// ----------------------------------------------------------------------------
package magc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MAX = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] GRAV_MIN_RST = CFG_DATA_W'(800);
  localparam logic [CFG_DATA_W-1:0] GRAV_MAX_RST = CFG_DATA_W'(1200);

endpackage

// File: rtl/magc_sqsum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magc_sqsum
// Three-stage front end: absolute value of each axis, squares, sum of squares.
// ----------------------------------------------------------------------------
module magc_sqsum #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic signed [AXIS_WIDTH-1:0] ax_i,
  input  logic signed [AXIS_WIDTH-1:0] ay_i,
  input  logic signed [AXIS_WIDTH-1:0] az_i,
  output logic                        vld_o,
  output logic [2*AXIS_WIDTH-1:0]     sum_o
);

  localparam int SUM_W = 2 * AXIS_WIDTH;

  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  logic [AXIS_WIDTH-1:0] abs_x_r, abs_y_r, abs_z_r;
  logic [AXIS_WIDTH-1:0] abs_x_nxt, abs_y_nxt, abs_z_nxt;
  logic [SUM_W-1:0]      sq_x_r, sq_y_r, sq_z_r;
  logic [SUM_W-1:0]      sum_r;

  // most negative value maps to 2^(W-1), which still fits unsigned
  assign abs_x_nxt = ax_i[AXIS_WIDTH-1] ? (~ax_i + 1'b1) : ax_i;
  assign abs_y_nxt = ay_i[AXIS_WIDTH-1] ? (~ay_i + 1'b1) : ay_i;
  assign abs_z_nxt = az_i[AXIS_WIDTH-1] ? (~az_i + 1'b1) : az_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_x_r <= abs_x_nxt;
      abs_y_r <= abs_y_nxt;
      abs_z_r <= abs_z_nxt;
      sq_x_r  <= SUM_W'(abs_x_r) * SUM_W'(abs_x_r);
      sq_y_r  <= SUM_W'(abs_y_r) * SUM_W'(abs_y_r);
      sq_z_r  <= SUM_W'(abs_z_r) * SUM_W'(abs_z_r);
      // 3 * 2^(2W-2) < 2^(2W): no carry out
      sum_r   <= sq_x_r + sq_y_r + sq_z_r;
    end
  end

  assign vld_o = s3_vld_r;
  assign sum_o = sum_r;

endmodule

// File: rtl/magc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magc_isqrt
// Pipelined restoring square root: one result bit per stage, AXIS_WIDTH stages.
// ----------------------------------------------------------------------------
module magc_isqrt #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [2*AXIS_WIDTH-1:0] rad_i,
  output logic                    vld_o,
  output logic [AXIS_WIDTH-1:0]   root_o
);

  localparam int SUM_W = 2 * AXIS_WIDTH;

  logic [SUM_W-1:0] rem_r [AXIS_WIDTH];
  logic [SUM_W-1:0] acc_r [AXIS_WIDTH];
  logic             vld_r [AXIS_WIDTH];

  for (genvar i = 0; i < AXIS_WIDTH; i++) begin : g_stage
    localparam int SH = SUM_W - 2 - 2 * i;
    localparam logic [SUM_W-1:0] TRIAL_BIT = SUM_W'(1) << SH;

    logic [SUM_W-1:0] rem_cur, acc_cur, trial;
    logic             vld_cur, take;
    logic [SUM_W-1:0] rem_nxt, acc_nxt;

    if (i == 0) begin : g_first
      assign rem_cur = rad_i;
      assign acc_cur = '0;
      assign vld_cur = vld_i;
    end else begin : g_next
      assign rem_cur = rem_r[i-1];
      assign acc_cur = acc_r[i-1];
      assign vld_cur = vld_r[i-1];
    end

    assign trial   = acc_cur + TRIAL_BIT;
    assign take    = rem_cur >= trial;
    assign rem_nxt = take ? (rem_cur - trial) : rem_cur;
    assign acc_nxt = take ? ((acc_cur >> 1) + TRIAL_BIT) : (acc_cur >> 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        acc_r[i] <= acc_nxt;
      end
    end
  end

  assign vld_o  = vld_r[AXIS_WIDTH-1];
  assign root_o = acc_r[AXIS_WIDTH-1][AXIS_WIDTH-1:0];

endmodule

// File: rtl/accel_magnitude_gravity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_magnitude_gravity_check
// Vector magnitude of a three-axis accelerometer sample (floor integer square
// root of the sum of squares) plus an inclusive gravity-window flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | in_accel_x, in_accel_y, in_accel_z
//  out     | out_valid / out_stall| out_vec_mag, out_gravity_like
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One beat per cycle in and out while the pipeline is not frozen. Each
//  sample passes abs, square, sum, one square-root bit per stage, then the
//  output register.
//  The whole pipeline moves together; it freezes only while a result sits in
//  the output register with out_stall high, and in_stall is raised then.
//  Synchronous active-low reset clears all valid bits and loads the window
//  registers with 800 and 1200 mg. cfg_ready is always high.
//
module accel_magnitude_gravity_check
  import magc_pkg::*;
#(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [AXIS_WIDTH-1:0] in_accel_x,
  input  logic signed [AXIS_WIDTH-1:0] in_accel_y,
  input  logic signed [AXIS_WIDTH-1:0] in_accel_z,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [MAG_W-1:0]            out_vec_mag,
  output logic                        out_gravity_like,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int SUM_W = 2 * AXIS_WIDTH;
  // compare width covers both the root and the 16-bit window bounds
  localparam int CMP_W = (AXIS_WIDTH > MAG_W) ? AXIS_WIDTH : MAG_W;

  logic                  adv;
  logic                  sq_vld, rt_vld;
  logic [SUM_W-1:0]      sq_sum;
  logic [AXIS_WIDTH-1:0] root;

  logic [CFG_DATA_W-1:0] grav_min_r, grav_max_r;

  logic                  out_vld_r;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic                  grav_r, grav_nxt;
  logic [CMP_W-1:0]      root_ext;

  // ---- global advance: the pipeline moves unless the output beat is held --
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  // ---- configuration registers --------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_min_r <= GRAV_MIN_RST;
      grav_max_r <= GRAV_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRAV_MIN: grav_min_r <= cfg_data;
        REG_GRAV_MAX: grav_max_r <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---- abs / square / sum --------------------------------------------------
  magc_sqsum #(
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_sqsum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (in_valid),
    .ax_i  (in_accel_x),
    .ay_i  (in_accel_y),
    .az_i  (in_accel_z),
    .vld_o (sq_vld),
    .sum_o (sq_sum)
  );

  // ---- square root ---------------------------------------------------------
  magc_isqrt #(
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (sq_vld),
    .rad_i  (sq_sum),
    .vld_o  (rt_vld),
    .root_o (root)
  );

  // ---- output stage: saturate, window compare on the full root -------------
  assign root_ext = CMP_W'(root);
  assign grav_nxt = (root_ext >= CMP_W'(grav_min_r)) && (root_ext <= CMP_W'(grav_max_r));

  if (AXIS_WIDTH > MAG_W) begin : g_sat
    assign mag_nxt = (|root[AXIS_WIDTH-1:MAG_W]) ? {MAG_W{1'b1}} : root[MAG_W-1:0];
  end else begin : g_nosat
    assign mag_nxt = MAG_W'(root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r  <= mag_nxt;
      grav_r <= grav_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_vec_mag      = mag_r;
  assign out_gravity_like = grav_r;

endmodule

// File: rtl/magc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magc_chk
// Port-level checker for the magnitude block, bound to the top level.
// ----------------------------------------------------------------------------
module magc_chk
  import magc_pkg::*;
#(
  parameter int AXIS_WIDTH = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic signed [AXIS_WIDTH-1:0] in_accel_x,
  input logic signed [AXIS_WIDTH-1:0] in_accel_y,
  input logic signed [AXIS_WIDTH-1:0] in_accel_z,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [MAG_W-1:0]            out_vec_mag,
  input logic                        out_gravity_like,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [CFG_IDX_W-1:0]        cfg_index,
  input logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [MAG_W-1:0] MAG_MAX_16 = MAG_W'(56755);

  logic [CFG_DATA_W-1:0] min_r, max_r;

  // shadow copy of the window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= GRAV_MIN_RST;
      max_r <= GRAV_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GRAV_MIN) begin
        min_r <= cfg_data;
      end
      if (cfg_index == REG_GRAV_MAX) begin
        max_r <= cfg_data;
      end
    end
  end

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // back-pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without held result");

  // window flag agrees with the shadow registers (no saturation case)
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (AXIS_WIDTH <= MAG_W) |->
      out_gravity_like == ((out_vec_mag >= min_r) && (out_vec_mag <= max_r)))
    else $error("gravity flag disagrees with window");

  // 16-bit axes cannot exceed sqrt(3) * 32768
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (AXIS_WIDTH == MAG_W) |-> out_vec_mag <= MAG_MAX_16)
    else $error("magnitude above largest reachable value");

endmodule

bind accel_magnitude_gravity_check magc_chk #(.AXIS_WIDTH(AXIS_WIDTH)) u_magc_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnitude and gravity-window bench
// Streams three-axis samples into the block under random valid gaps and
// output stalls, with one long output hold-off that fills the pipeline.
// Every result beat is checked in order against a bit-exact model of the
// floor square root and the window flag. The window registers are rewritten
// between bursts while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import magc_pkg::*;

  localparam int AXIS_W      = 16;
  localparam int LATENCY     = AXIS_W + 4;
  localparam int HOLD_CYCLES = 90;      // long receiver hold-off
  localparam int QUIET_LIMIT = 5000;    // cycles with no beat anywhere

  // No register sits at this index; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

  localparam logic signed [AXIS_W-1:0] AXIS_MIN = {1'b1, {(AXIS_W-1){1'b0}}};
  localparam logic signed [AXIS_W-1:0] AXIS_MAX = {1'b0, {(AXIS_W-1){1'b1}}};

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic             in_window;
  } mag_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the window, predicts each accepted
  // sample and checks result beats in arrival order.
  // --------------------------------------------------------------------------
  class magnitude_book;
    mag_result_t      outstanding[$];
    logic [CFG_DATA_W-1:0] win_min = GRAV_MIN_RST;
    logic [CFG_DATA_W-1:0] win_max = GRAV_MAX_RST;
    int unsigned      failures = 0;

    function void set_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GRAV_MIN) win_min = val;
      else if (idx == REG_GRAV_MAX) win_max = val;
    endfunction

    // Two's complement magnitude, one bit wider so the most negative value fits.
    function logic [AXIS_W:0] axis_abs(logic signed [AXIS_W-1:0] v);
      logic signed [AXIS_W:0] w;
      w = v;
      return w[AXIS_W] ? (AXIS_W+1)'(-w) : (AXIS_W+1)'(w);
    endfunction

    // Restoring square root, 32 stages, trial bit 2^62 down to 2^0.
    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] acc;
      logic [63:0] trial;
      rem   = v;
      acc   = '0;
      trial = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
        if (rem >= acc + trial) begin
          rem = rem - (acc + trial);
          acc = (acc >> 1) + trial;
        end else begin
          acc = acc >> 1;
        end
        trial = trial >> 2;
      end
      return acc;
    endfunction

    function void note_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                              logic signed [AXIS_W-1:0] z);
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] az;
      logic [63:0] mag;
      mag_result_t r;
      ax  = 64'(axis_abs(x));
      ay  = 64'(axis_abs(y));
      az  = 64'(axis_abs(z));
      mag = floor_root(ax * ax + ay * ay + az * az);
      r.magnitude = (mag > 64'hFFFF) ? MAG_W'(16'hFFFF) : MAG_W'(mag);
      // flag uses the unsaturated value
      r.in_window = (mag >= 64'(win_min)) && (mag <= 64'(win_max));
      outstanding.push_back(r);
    endfunction

    function void check_result(logic [MAG_W-1:0] mag, logic flag);
      mag_result_t want;
      if (outstanding.size() == 0) begin
        $error("result beat with nothing outstanding: vec_mag %0d gravity_like %0b",
               mag, flag);
        failures++;
        return;
      end
      want = outstanding.pop_front();
      if (mag !== want.magnitude) begin
        $error("vec_mag: expected %0d, got %0d", want.magnitude, mag);
        failures++;
      end
      if (flag !== want.in_window) begin
        $error("gravity_like: expected %0b, got %0b", want.in_window, flag);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals - every block input starts at a known value
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [AXIS_W-1:0] in_accel_x = '0;
  logic signed [AXIS_W-1:0] in_accel_y = '0;
  logic signed [AXIS_W-1:0] in_accel_z = '0;

  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [MAG_W-1:0]         out_vec_mag;
  logic                     out_gravity_like;

  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = REG_GRAV_MIN;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;

  // Shared with the receiver process
  logic steady      = 1'b0;   // no idling on either side while set
  logic squeeze_req = 1'b0;   // asks the receiver for one long hold-off

  magnitude_book book;

  accel_magnitude_gravity_check #(.AXIS_WIDTH(AXIS_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vec_mag      (out_vec_mag),
    .out_gravity_like (out_gravity_like),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Receiver: random stall at each falling edge, or a counted hold-off when
  // the stimulus asks for one. The sender keeps offering meanwhile, so the
  // pipeline fills and in_stall must rise.
  // --------------------------------------------------------------------------
  int hold_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (squeeze_req) begin
      squeeze_req = 1'b0;
      hold_left   = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 38);
    end
  end

  // Result beats are checked at the rising edge they are accepted on.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_result(out_vec_mag, out_gravity_like);
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which no beat moves on any channel.
  // --------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks - inputs change on the falling edge only
  // --------------------------------------------------------------------------

  // One sample beat; random gaps before it unless in a steady stretch.
  task automatic push_sample(input logic signed [AXIS_W-1:0] x,
                             input logic signed [AXIS_W-1:0] y,
                             input logic signed [AXIS_W-1:0] z);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_sample(x, y, z);
  endtask

  // Axis value: full range, near one g, or an edge value.
  function automatic logic signed [AXIS_W-1:0] pick_axis(int unsigned style);
    case (style)
      0: return AXIS_W'($urandom_range(0, 65535));
      1: return AXIS_W'($signed($urandom_range(0, 3000)) - 1500);
      default: begin
        case ($urandom_range(0, 4))
          0: return AXIS_MIN;
          1: return AXIS_MAX;
          2: return AXIS_W'(-1);
          3: return AXIS_W'(1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic push_random(input int n);
    int unsigned roll;
    int unsigned style;
    for (int i = 0; i < n; i++) begin
      roll  = $urandom_range(0, 9);
      style = (roll < 5) ? 0 : (roll < 8) ? 1 : 2;
      push_sample(pick_axis(style), pick_axis(style), pick_axis(style));
    end
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.outstanding.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_window(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;

    book = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset window (800..1200 mg).
    push_sample(0, 0, 0);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN);      // largest magnitude
    push_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX);
    push_sample(AXIS_MIN, 0, 0);                    // most negative, squared exactly
    push_sample(0, AXIS_MAX, 0);
    push_sample(0, 0, -1);
    push_sample(1000, 0, 0);
    push_sample(800, 0, 0);                         // on the lower edge
    push_sample(799, 0, 0);
    push_sample(1200, 0, 0);                        // on the upper edge
    push_sample(1201, 0, 0);
    push_sample(0, -800, 0);
    push_sample(600, -800, 0);
    push_sample(3, 4, -12);
    push_sample(1, 1, 1);                           // floor, not rounding
    push_sample(2, -2, 2);
    push_sample(-1, -1, -1);
    push_sample(16384, -16384, 16384);
    push_sample(AXIS_MIN, AXIS_MAX, 0);
    push_sample(577, -577, 577);                    // just under 1000
    push_sample(16'sh5555, -16'sh2AAB, 16'sh7FFE);
    push_random(80);
    drain();

    // Widest window: everything is gravity-like.
    write_reg(REG_GRAV_MIN, '0);
    write_reg(REG_GRAV_MAX, 16'hFFFF);
    push_random(60);
    drain();

    // Inverted window: flag never set. The spare index must leave it alone.
    write_reg(REG_GRAV_MIN, 16'hFFFF);
    write_reg(REG_GRAV_MAX, '0);
    write_reg(REG_SPARE, 16'(($urandom_range(0, 65535))));
    push_sample(0, 0, 0);
    push_random(60);
    drain();

    // Single-point window at the top magnitude.
    write_reg(REG_GRAV_MIN, 16'd56755);
    write_reg(REG_GRAV_MAX, 16'd56755);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN);
    push_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MAX);
    push_random(40);
    drain();

    // Back-to-back stretch with no idling on either side.
    write_reg(REG_GRAV_MIN, 16'd900);
    write_reg(REG_GRAV_MAX, 16'd1100);
    steady = 1'b1;
    push_random(120);
    drain();
    steady = 1'b0;

    // Random windows; the first burst also gets the long output hold-off.
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 1) == 0) begin
        lo = 16'($urandom_range(0, 1500));
        hi = lo + 16'($urandom_range(0, 1500));
      end else begin
        lo = 16'($urandom_range(0, 65535));
        hi = 16'($urandom_range(0, 65535));
      end
      write_reg(REG_GRAV_MIN, lo);
      write_reg(REG_GRAV_MAX, hi);
      if (p == 0) squeeze_req = 1'b1;
      push_random(40);
      drain();
    end

    if (book.outstanding.size() != 0) begin
      $error("%0d expected results never arrived", book.outstanding.size());
      book.failures++;
    end

    if (book.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/magc_pkg.sv
rtl/magc_sqsum.sv
rtl/magc_isqrt.sv
rtl/accel_magnitude_gravity_check.sv
rtl/magc_chk.sv
tb/testbench.sv
